### rtl/dcorr_pkg.sv
// shared constants and types for the displacement correlation block
package dcorr_pkg;

  localparam int MAX_HEIGHT = 32;
  localparam int MAX_WIDTH  = 32;
  localparam int MAX_DEPTH  = 32;
  localparam int MAX_RADIUS = 3;

  localparam int ROW_W   = 5;
  localparam int COL_W   = 5;
  localparam int CH_W    = 5;
  localparam int ADDR_W  = ROW_W + COL_W + CH_W;
  localparam int DEPTH_N = MAX_HEIGHT * MAX_WIDTH * MAX_DEPTH;
  localparam int ACC_W   = 42;
  localparam int QUO_W   = 32;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 3'd4;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic       op;
    logic [4:0] row;
    logic [4:0] col;
    logic [4:0] channel;
    logic [15:0] a_value;
    logic [15:0] b_value;
  } item_t;

  typedef struct packed {
    logic [31:0] correlation;
    logic [5:0]  disp_idx;
    logic        out_of_bounds;
    logic        last;
  } result_t;

endpackage

### rtl/displacement_correlation.sv
// top level of the displacement correlation block
//
// in_ beats carry either a load (operation 0) of one element of both maps at
// (row, col, channel), or a query (operation 1) of pixel (row, col). a query
// yields (2r+1)^2 out_ beats in displacement order, tlast on the final one.
// each in-bounds displacement passes through a setup state, a multiply-accumulate
// over depth channels through one registered-read map port per map, the serial
// divider and an output state; out-of-bounds displacements go from the setup
// state straight to the output state.
// a two-entry queue sits between the input stage and the compute engine, so
// loads are taken while a query is still running until the queue fills.
// the output register holds each result until out_tready; the engine waits
// on it and does not drop or repeat results.
// cfg_ beats write register cfg_index (stride, radius_steps, height, width,
// depth) and are always accepted; write only while idle.
// rst_n is synchronous; it restores register defaults and empties the queue.
// map contents are undefined until loaded.
module displacement_correlation
  import dcorr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // row, col, channel, a_value, b_value, zero pad
  input  logic        in_tuser,  // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // correlation, displacement index, out_of_bounds, zero pad
  output logic        out_tlast
);

  item_t in_item, q_item;
  logic  q_valid, q_ready, b_valid, b_ready;
  item_t b_item;
  result_t res;
  logic [3:0] stride;
  logic [1:0] radius;
  logic [5:0] height, width, depth;

  assign in_item.op      = in_tuser;
  assign in_item.row     = in_tdata[4:0];
  assign in_item.col     = in_tdata[9:5];
  assign in_item.channel = in_tdata[14:10];
  assign in_item.a_value = in_tdata[30:15];
  assign in_item.b_value = in_tdata[46:31];

  dcorr_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .stride(stride), .radius(radius), .height(height), .width(width), .depth(depth));

  dcorr_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_valid(q_valid), .wr_ready(q_ready), .wr_data(q_item),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_item));

  dcorr_back u_back (
    .clk(clk), .rst_n(rst_n), .item_valid(b_valid), .item_ready(b_ready), .item(b_item),
    .stride(stride), .radius(radius), .height(height), .width(width), .depth(depth),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(res));

  assign out_tdata = {1'b0, res.out_of_bounds, res.disp_idx, res.correlation};
  assign out_tlast = res.last;

endmodule

### rtl/dcorr_ram.sv
// generic single-port-write, single-port-read ram with registered read
module dcorr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/dcorr_fifo.sv
// short item queue between front and back parts
module dcorr_fifo
  import dcorr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  item_t wr_data,
  output logic  rd_valid,
  input  logic  rd_ready,
  output item_t rd_data
);

  item_t      buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = buf_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= wr_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/dcorr_div.sv
// restoring signed divider, one quotient bit per cycle
module dcorr_div
  import dcorr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] dividend,
  input  logic [5:0]              divisor,
  output logic                    busy,
  output logic                    done,
  output logic [QUO_W-1:0]        quotient
);

  logic [ACC_W-1:0] q_r;
  logic [6:0]       rem_r;
  logic [5:0]       den_r;
  logic             neg_r;
  logic [5:0]       cnt_r;
  logic             busy_r, done_r;
  logic [6:0]       trial;
  logic [ACC_W-1:0] mag;
  logic [ACC_W-1:0] qneg;

  assign mag   = dividend[ACC_W-1] ? (~dividend + 1'b1) : dividend;
  assign trial = {rem_r[5:0], q_r[ACC_W-1]};
  assign qneg  = neg_r ? (~q_r + 1'b1) : q_r;
  assign busy  = busy_r;
  assign done  = done_r;
  assign quotient = qneg[QUO_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        q_r    <= mag;
        rem_r  <= '0;
        den_r  <= divisor;
        neg_r  <= dividend[ACC_W-1];
        cnt_r  <= 6'(ACC_W - 1);
      end else if (busy_r) begin
        if (trial >= {1'b0, den_r}) begin
          rem_r <= trial - {1'b0, den_r};
          q_r   <= {q_r[ACC_W-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[ACC_W-2:0], 1'b0};
        end
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 6'd1;
        end
      end
    end
  end

endmodule

### rtl/dcorr_back.sv
// back part: map stores, displacement walk, multiply-accumulate, divide
module dcorr_back
  import dcorr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  input  logic [3:0]  stride,
  input  logic [1:0]  radius,
  input  logic [5:0]  height,
  input  logic [5:0]  width,
  input  logic [5:0]  depth,
  output logic        res_valid,
  input  logic        res_ready,
  output result_t     res
);

  typedef enum logic [2:0] {S_IDLE, S_OFF, S_MAC, S_DRAIN, S_DIV, S_OUT} state_t;

  state_t state_r;
  logic [4:0] row_r, col_r;
  logic [2:0] p_r, q_r;
  logic [5:0] idx_r;
  logic [4:0] m_r;
  logic [4:0] br_r, bc_r;
  logic       ok_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [31:0] prod_r;
  logic [1:0] pv_r;
  result_t res_r;
  logic    res_valid_r;

  logic [2:0] n2;
  logic signed [8:0] br_s, bc_s;
  logic       disp_in;
  logic [ADDR_W-1:0] a_addr, b_addr, waddr;
  logic [15:0] a_rd, b_rd;
  logic        we;
  logic        div_start, div_busy, div_done;
  logic [QUO_W-1:0] quo;
  logic        last_off;

  assign n2 = {radius, 1'b0};
  assign br_s = $signed({4'b0, row_r}) + ($signed({6'b0, p_r}) - $signed({7'b0, radius}))
                * $signed({5'b0, stride});
  assign bc_s = $signed({4'b0, col_r}) + ($signed({6'b0, q_r}) - $signed({7'b0, radius}))
                * $signed({5'b0, stride});
  assign disp_in = ok_r && !br_s[8] && (br_s < $signed({3'b0, height}))
                   && !bc_s[8] && (bc_s < $signed({3'b0, width}));
  assign last_off = (p_r == n2) && (q_r == n2);

  assign we     = item_valid && item_ready && (item.op == OP_LOAD);
  assign waddr  = {item.row, item.col, item.channel};
  assign a_addr = {row_r, col_r, m_r};
  assign b_addr = {br_r, bc_r, m_r};

  dcorr_ram #(.WIDTH(16), .DEPTH(DEPTH_N)) u_ram_a (
    .clk(clk), .we(we), .waddr(waddr), .wdata(item.a_value), .raddr(a_addr), .rdata(a_rd));
  dcorr_ram #(.WIDTH(16), .DEPTH(DEPTH_N)) u_ram_b (
    .clk(clk), .we(we), .waddr(waddr), .wdata(item.b_value), .raddr(b_addr), .rdata(b_rd));

  assign div_start = (state_r == S_DRAIN) && (pv_r == 2'b00);

  dcorr_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(acc_r), .divisor(depth),
    .busy(div_busy), .done(div_done), .quotient(quo));

  assign item_ready = (state_r == S_IDLE);
  assign res_valid  = res_valid_r;
  assign res        = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_valid_r <= 1'b0;
      pv_r        <= '0;
      acc_r       <= '0;
    end else begin
      if (res_valid_r && res_ready) res_valid_r <= 1'b0;
      pv_r[1] <= pv_r[0];
      if (pv_r[0]) prod_r <= $signed(a_rd) * $signed(b_rd);
      if (pv_r[1]) acc_r <= acc_r + ACC_W'(prod_r);
      case (state_r)
        S_IDLE: begin
          if (item_valid && item.op == OP_QUERY) begin
            row_r <= item.row;
            col_r <= item.col;
            ok_r  <= ({1'b0, item.row} < height) && ({1'b0, item.col} < width);
            p_r   <= '0;
            q_r   <= '0;
            idx_r <= '0;
            state_r <= S_OFF;
          end
        end
        S_OFF: begin
          if (!res_valid_r || res_ready) begin
            res_r.disp_idx <= idx_r;
            res_r.last     <= last_off;
            if (disp_in) begin
              br_r  <= br_s[4:0];
              bc_r  <= bc_s[4:0];
              m_r   <= '0;
              acc_r <= '0;
              res_r.out_of_bounds <= 1'b0;
              state_r <= S_MAC;
            end else begin
              res_r.correlation   <= '0;
              res_r.out_of_bounds <= 1'b1;
              res_valid_r <= 1'b1;
              state_r <= S_OUT;
            end
          end
        end
        S_MAC: begin
          pv_r[0] <= 1'b1;
          if ({1'b0, m_r} == depth - 6'd1) begin
            state_r <= S_DRAIN;
          end else begin
            m_r <= m_r + 5'd1;
          end
        end
        S_DRAIN: begin
          pv_r[0] <= 1'b0;
          if (pv_r == 2'b00 && !pv_r[1]) state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res_r.correlation <= quo;
            res_valid_r <= 1'b1;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (last_off) begin
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + 6'd1;
            if (q_r == n2) begin
              q_r <= '0;
              p_r <= p_r + 3'd1;
            end else begin
              q_r <= q_r + 3'd1;
            end
            state_r <= S_OFF;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (state_r == S_DIV && div_busy) state_r <= S_DIV;
    end
  end

endmodule

### rtl/dcorr_front.sv
// front part: configuration registers, range clamping, input pass-through to the queue
module dcorr_front
  import dcorr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  item_t                in_item,
  output logic                 q_valid,
  input  logic                 q_ready,
  output item_t                q_item,
  output logic [3:0]           stride,
  output logic [1:0]           radius,
  output logic [5:0]           height,
  output logic [5:0]           width,
  output logic [5:0]           depth
);

  logic [3:0] stride_r;
  logic [1:0] radius_r;
  logic [5:0] height_r, width_r, depth_r;
  logic       drop;

  assign cfg_ready = 1'b1;

  // loads never fall outside the 32x32x32 store with 5-bit indexes, so all pass
  assign drop     = 1'b0;
  assign q_valid  = in_valid && !drop;
  assign in_ready = q_ready || drop;
  assign q_item   = in_item;

  assign stride = (stride_r == 4'd0) ? 4'd1 : stride_r;
  assign radius = (radius_r == 2'd0) ? 2'd1 : radius_r;
  assign height = (height_r == 6'd0) ? 6'd1 : (height_r > 6'(MAX_HEIGHT)) ? 6'(MAX_HEIGHT)
                  : height_r;
  assign width  = (width_r == 6'd0) ? 6'd1 : (width_r > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH)
                  : width_r;
  assign depth  = (depth_r == 6'd0) ? 6'd1 : (depth_r > 6'(MAX_DEPTH)) ? 6'(MAX_DEPTH)
                  : depth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= 4'd1;
      radius_r <= 2'd1;
      height_r <= 6'd32;
      width_r  <= 6'd32;
      depth_r  <= 6'd32;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STRIDE: stride_r <= cfg_data[3:0];
        REG_RADIUS: radius_r <= cfg_data[1:0];
        REG_HEIGHT: height_r <= cfg_data[5:0];
        REG_WIDTH:  width_r  <= cfg_data[5:0];
        REG_DEPTH:  depth_r  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

endmodule

### sim/tb.sv
// testbench for displacement_correlation: loads random maps, checks every query result
`timescale 1ns / 1ps

module tb;
  import dcorr_pkg::*;

  localparam logic [2:0] REG_NONE = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;

  displacement_correlation uut (.*);

  always #5 clk = ~clk;

  typedef struct {
    bit    wait_drain;
    item_t it;
  } beat_t;

  beat_t       pending_beats[$];
  result_t     expected_results[$];
  item_t       cur_beat;
  int          errors = 0;
  int          results_seen = 0;
  bit          quiet = 1'b0;
  longint      cycles = 0;

  // predictor state
  logic signed [15:0] map_a [DEPTH_N];
  logic signed [15:0] map_b [DEPTH_N];
  bit                 loaded [DEPTH_N];
  logic [3:0] p_stride = 4'd1;
  logic [1:0] p_radius = 2'd1;
  logic [5:0] p_height = 6'd32;
  logic [5:0] p_width  = 6'd32;
  logic [5:0] p_depth  = 6'd32;

  function automatic int clampi(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic predict_beat(input item_t it);
    int st, r, h, w, d, n, br, bc;
    bit pix_ok, disp_in;
    longint acc;
    result_t res;
    if (it.op == OP_LOAD) begin
      map_a[{it.row, it.col, it.channel}] = it.a_value;
      map_b[{it.row, it.col, it.channel}] = it.b_value;
      return;
    end
    st = (p_stride == 0) ? 1 : p_stride;
    r = clampi(p_radius, 1, MAX_RADIUS);
    h = clampi(p_height, 1, MAX_HEIGHT);
    w = clampi(p_width, 1, MAX_WIDTH);
    d = clampi(p_depth, 1, MAX_DEPTH);
    n = 2 * r + 1;
    pix_ok = (it.row < h) && (it.col < w);
    for (int p = 0; p < n; p++) begin
      for (int q = 0; q < n; q++) begin
        br = int'(it.row) + (p - r) * st;
        bc = int'(it.col) + (q - r) * st;
        disp_in = pix_ok && br >= 0 && br < h && bc >= 0 && bc < w;
        acc = 0;
        if (disp_in) begin
          for (int m = 0; m < d; m++)
            acc += longint'(map_a[{it.row, it.col, 5'(m)}]) *
                   longint'(map_b[{5'(br), 5'(bc), 5'(m)}]);
          acc = acc / d;
        end
        res.correlation   = acc[31:0];
        res.disp_idx      = 6'(p * n + q);
        res.out_of_bounds = !disp_in;
        res.last          = (p == n - 1) && (q == n - 1);
        expected_results.push_back(res);
      end
    end
  endtask

  // driver
  int gap = 0;
  always @(posedge clk) begin
    bit nv;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_beat(cur_beat);
      nv = in_tvalid && !in_tready;
      if (!nv) begin
        if (gap > 0) begin
          gap--;
        end else if (pending_beats.size() > 0 &&
                     !(pending_beats[0].wait_drain && expected_results.size() > 0)) begin
          if (!quiet && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 16);
          end else begin
            cur_beat = pending_beats.pop_front().it;
            nv = 1'b1;
            in_tdata <= {1'b0, cur_beat.b_value, cur_beat.a_value, cur_beat.channel,
                         cur_beat.col, cur_beat.row};
            in_tuser <= cur_beat.op;
          end
        end
      end
      in_tvalid <= nv;
    end
  end

  // monitor and result-side backpressure
  int stall = 0;
  int hold_cnt = 0;
  bit held = 1'b0;
  always @(posedge clk) begin
    result_t want;
    bit nr;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result beat %h", out_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[31:0] !== want.correlation) begin
            $error("correlation expected %0d got %0d", $signed(want.correlation),
                   $signed(out_tdata[31:0]));
            errors++;
          end
          if (out_tdata[37:32] !== want.disp_idx) begin
            $error("disp_idx expected %0d got %0d", want.disp_idx, out_tdata[37:32]);
            errors++;
          end
          if (out_tdata[38] !== want.out_of_bounds) begin
            $error("out_of_bounds expected %0b got %0b", want.out_of_bounds, out_tdata[38]);
            errors++;
          end
          if (out_tlast !== want.last) begin
            $error("last expected %0b got %0b", want.last, out_tlast);
            errors++;
          end
        end
      end
      nr = 1'b1;
      if (hold_cnt > 0) begin
        hold_cnt--;
        nr = 1'b0;
      end else if (!held && results_seen >= 60) begin
        held = 1'b1;
        hold_cnt = 400;
        nr = 1'b0;
      end else if (stall > 0) begin
        stall--;
        nr = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 16);
        nr = 1'b0;
      end
      out_tready <= nr;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val, input int bits);
    logic [31:0] data;
    data = ($urandom << bits) | val;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_STRIDE: p_stride = data[3:0];
      REG_RADIUS: p_radius = data[1:0];
      REG_HEIGHT: p_height = data[5:0];
      REG_WIDTH:  p_width  = data[5:0];
      REG_DEPTH:  p_depth  = data[5:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_beats.size() > 0 || in_tvalid || expected_results.size() > 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic add_beat(input bit op, input int row, input int col, input int ch,
                          input int a, input int b, input bit wd = 1'b0);
    beat_t bt;
    bt.wait_drain   = wd;
    bt.it.op        = op;
    bt.it.row       = 5'(row);
    bt.it.col       = 5'(col);
    bt.it.channel   = 5'(ch);
    bt.it.a_value   = 16'(a);
    bt.it.b_value   = 16'(b);
    if (op == OP_LOAD) loaded[{5'(row), 5'(col), 5'(ch)}] = 1'b1;
    pending_beats.push_back(bt);
  endtask

  task automatic start_phase(input int st, input int rad, input int h, input int w,
                             input int d, input int extra);
    int eh, ew, ed;
    drain();
    write_reg(REG_STRIDE, st, 4);
    write_reg(REG_RADIUS, rad, 2);
    write_reg(REG_HEIGHT, h, 6);
    write_reg(REG_WIDTH, w, 6);
    write_reg(REG_DEPTH, d, 6);
    eh = clampi(h, 1, 32);
    ew = clampi(w, 1, 32);
    ed = clampi(d, 1, 32);
    for (int i = 0; i < eh; i++)
      for (int j = 0; j < ew; j++)
        for (int k = 0; k < ed; k++)
          if (!loaded[{5'(i), 5'(j), 5'(k)}])
            add_beat(OP_LOAD, i, j, k, $urandom, $urandom);
    for (int n = 0; n < extra; n++) begin
      if ($urandom_range(0, 99) < 35) begin
        if ($urandom_range(0, 4) != 0)
          add_beat(OP_QUERY, $urandom_range(0, eh - 1), $urandom_range(0, ew - 1),
                   $urandom, $urandom, $urandom);
        else
          add_beat(OP_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if ($urandom_range(0, 4) != 0) begin
        add_beat(OP_LOAD, $urandom_range(0, eh - 1), $urandom_range(0, ew - 1),
                 $urandom_range(0, ed - 1), $urandom, $urandom);
      end else begin
        add_beat(OP_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    write_reg(REG_NONE, $urandom_range(0, 63), 6);

    start_phase(1, 1, 3, 3, 2, 0);
    // extreme samples, corner, center and outside pixels
    add_beat(OP_LOAD, 0, 0, 0, 16'h8000, 16'h8000);
    add_beat(OP_LOAD, 0, 0, 1, 16'h7fff, 16'h8000);
    add_beat(OP_LOAD, 1, 1, 0, 16'h7fff, 16'h7fff);
    add_beat(OP_LOAD, 1, 1, 1, 16'hffff, 16'h0001);
    add_beat(OP_LOAD, 31, 31, 31, 16'h1234, 16'h5678);
    add_beat(OP_QUERY, 0, 0, 0, 0, 0);
    add_beat(OP_QUERY, 1, 1, 0, 0, 0);
    add_beat(OP_QUERY, 2, 2, 0, 0, 0);
    add_beat(OP_QUERY, 31, 0, 0, 0, 0);
    add_beat(OP_QUERY, 0, 31, 31, 16'hffff, 16'hffff, 1'b1);
    add_beat(OP_QUERY, 2, 0, 0, 0, 0);

    start_phase(0, 0, 3, 3, 3, 20);
    start_phase(15, 3, 32, 1, 1, 20);
    start_phase(2, 3, 0, 40, 1, 20);
    start_phase(1, 3, 1, 2, 63, 8);
    start_phase(3, 2, 5, 5, 0, 20);
    start_phase(1, 3, 4, 4, 4, 60);
    pending_beats[$urandom_range(0, pending_beats.size() - 1)].wait_drain = 1'b1;
    quiet = 1'b1;
    start_phase(2, 2, 3, 4, 3, 50);
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

### displacement_correlation.f
rtl/dcorr_pkg.sv
rtl/dcorr_ram.sv
rtl/dcorr_fifo.sv
rtl/dcorr_div.sv
rtl/dcorr_back.sv
rtl/dcorr_front.sv
rtl/displacement_correlation.sv
sim/tb.sv
